>>> design/sws_pkg.sv
// shared types and constants for the shell word splitter
// no dependencies; imported by sws_parser, sws_queue and shell_word_splitter
`timescale 1ns / 1ps
`default_nettype none

package sws_pkg;

    // bytes with a special meaning to the parser
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NL        = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_DOLLAR    = 8'h24;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_BACKTICK  = 8'h60;

    // quoting states
    localparam logic [2:0] ST_DELIM      = 3'd0;
    localparam logic [2:0] ST_BSLASH     = 3'd1;
    localparam logic [2:0] ST_UNQ        = 3'd2;
    localparam logic [2:0] ST_UNQ_BSLASH = 3'd3;
    localparam logic [2:0] ST_SQ         = 3'd4;
    localparam logic [2:0] ST_DQ         = 3'd5;
    localparam logic [2:0] ST_DQ_BSLASH  = 3'd6;
    localparam logic [2:0] ST_COMMENT    = 3'd7;

    // record kinds
    localparam logic [1:0] K_CHAR = 2'd0;
    localparam logic [1:0] K_EOW  = 2'd1;
    localparam logic [1:0] K_EOC  = 2'd2;
    localparam logic [1:0] K_ERR  = 2'd3;

    // one byte gives at most this many records
    localparam int MAX_RECS = 3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic       last;
    } record_t;

    // records produced by one byte, valid in slots below count
    typedef struct packed {
        logic [1:0]              count;
        record_t [MAX_RECS-1:0] rec;
    } rec_group_t;

    function automatic record_t mk_rec(input logic [1:0] kind, input logic [7:0] ch);
        record_t r;
        r.kind = kind;
        r.ch   = (kind == K_CHAR) ? ch : 8'h00;
        r.last = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/sws_parser.sv
// quoting state machine: turns one byte into up to three records
// depends on sws_pkg
`timescale 1ns / 1ps
`default_nettype none

module sws_parser (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire logic [7:0]         ch,
    output sws_pkg::rec_group_t     group
);
    import sws_pkg::*;

    logic [2:0]  state_reg;
    logic [2:0]  state_next;
    logic        word_open_reg;
    logic        word_open_next;
    rec_group_t  grp;
    logic        done;
    logic        blank;

    assign blank = ch inside {CH_TAB, CH_SPACE, CH_NL};

    always_comb
    begin
        state_next     = state_reg;
        word_open_next = word_open_reg;
        done           = 1'b0;
        grp            = '0;
        case (state_reg)
            ST_DELIM, ST_COMMENT:
            begin
                if (ch == CH_NUL)
                begin
                    if (word_open_reg)
                    begin
                        grp.rec[0] = mk_rec(K_EOW, 8'h00);
                        grp.rec[1] = mk_rec(K_EOC, 8'h00);
                        grp.count  = 2'd2;
                    end
                    else
                    begin
                        grp.rec[0] = mk_rec(K_EOC, 8'h00);
                        grp.count  = 2'd1;
                    end
                    done = 1'b1;
                end
                else if (state_reg == ST_COMMENT)
                begin
                    // newline ends the comment but leaves an open word open
                    if (ch == CH_NL)
                        state_next = ST_DELIM;
                end
                else if (ch == CH_SQUOTE)
                    state_next = ST_SQ;
                else if (ch == CH_DQUOTE)
                    state_next = ST_DQ;
                else if (ch == CH_BACKSLASH)
                    state_next = ST_BSLASH;
                else if (blank)
                    state_next = ST_DELIM;
                else if (ch == CH_HASH)
                    state_next = ST_COMMENT;
                else
                begin
                    grp.rec[0]     = mk_rec(K_CHAR, ch);
                    grp.count      = 2'd1;
                    word_open_next = 1'b1;
                    state_next     = ST_UNQ;
                end
            end
            ST_BSLASH, ST_UNQ_BSLASH:
            begin
                if (ch == CH_NUL)
                begin
                    // trailing backslash is kept as a character
                    grp.rec[0] = mk_rec(K_CHAR, CH_BACKSLASH);
                    grp.rec[1] = mk_rec(K_EOW, 8'h00);
                    grp.rec[2] = mk_rec(K_EOC, 8'h00);
                    grp.count  = 2'd3;
                    done       = 1'b1;
                end
                else if (ch == CH_NL)
                    state_next = (state_reg == ST_BSLASH) ? ST_DELIM : ST_UNQ;
                else
                begin
                    grp.rec[0]     = mk_rec(K_CHAR, ch);
                    grp.count      = 2'd1;
                    word_open_next = 1'b1;
                    state_next     = ST_UNQ;
                end
            end
            ST_UNQ:
            begin
                if (ch == CH_NUL)
                begin
                    grp.rec[0] = mk_rec(K_EOW, 8'h00);
                    grp.rec[1] = mk_rec(K_EOC, 8'h00);
                    grp.count  = 2'd2;
                    done       = 1'b1;
                end
                else if (ch == CH_SQUOTE)
                    state_next = ST_SQ;
                else if (ch == CH_DQUOTE)
                    state_next = ST_DQ;
                else if (ch == CH_BACKSLASH)
                    state_next = ST_UNQ_BSLASH;
                else if (blank)
                begin
                    grp.rec[0]     = mk_rec(K_EOW, 8'h00);
                    grp.count      = 2'd1;
                    word_open_next = 1'b0;
                    state_next     = ST_DELIM;
                end
                else if (ch == CH_HASH)
                    state_next = ST_COMMENT;
                else
                begin
                    grp.rec[0]     = mk_rec(K_CHAR, ch);
                    grp.count      = 2'd1;
                    word_open_next = 1'b1;
                end
            end
            ST_SQ:
            begin
                if (ch == CH_NUL)
                begin
                    grp.rec[0] = mk_rec(K_ERR, 8'h00);
                    grp.count  = 2'd1;
                    done       = 1'b1;
                end
                else if (ch == CH_SQUOTE)
                    state_next = ST_UNQ;
                else
                begin
                    grp.rec[0]     = mk_rec(K_CHAR, ch);
                    grp.count      = 2'd1;
                    word_open_next = 1'b1;
                end
            end
            ST_DQ:
            begin
                if (ch == CH_NUL)
                begin
                    grp.rec[0] = mk_rec(K_ERR, 8'h00);
                    grp.count  = 2'd1;
                    done       = 1'b1;
                end
                else if (ch == CH_DQUOTE)
                    state_next = ST_UNQ;
                else if (ch == CH_BACKSLASH)
                    state_next = ST_DQ_BSLASH;
                else
                begin
                    grp.rec[0]     = mk_rec(K_CHAR, ch);
                    grp.count      = 2'd1;
                    word_open_next = 1'b1;
                end
            end
            default:
            begin
                // backslash inside double quotes
                if (ch == CH_NUL)
                begin
                    grp.rec[0] = mk_rec(K_ERR, 8'h00);
                    grp.count  = 2'd1;
                    done       = 1'b1;
                end
                else if (ch == CH_NL)
                    state_next = ST_DQ;
                else if (ch inside {CH_DOLLAR, CH_BACKTICK, CH_DQUOTE, CH_BACKSLASH})
                begin
                    grp.rec[0]     = mk_rec(K_CHAR, ch);
                    grp.count      = 2'd1;
                    word_open_next = 1'b1;
                    state_next     = ST_DQ;
                end
                else
                begin
                    grp.rec[0]     = mk_rec(K_CHAR, CH_BACKSLASH);
                    grp.rec[1]     = mk_rec(K_CHAR, ch);
                    grp.count      = 2'd2;
                    word_open_next = 1'b1;
                    state_next     = ST_DQ;
                end
            end
        endcase

        if (done)
        begin
            state_next     = ST_DELIM;
            word_open_next = 1'b0;
        end

        case (grp.count)
            2'd1:    grp.rec[0].last = 1'b1;
            2'd2:    grp.rec[1].last = 1'b1;
            2'd3:    grp.rec[2].last = 1'b1;
            default: ;
        endcase
    end

    assign group = grp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_DELIM;
            word_open_reg <= 1'b0;
        end
        else if (step)
        begin
            state_reg     <= state_next;
            word_open_reg <= word_open_next;
        end
    end

endmodule

`default_nettype wire

>>> design/sws_queue.sv
// four-entry result queue: takes up to three records at once, gives one a cycle while pop is high
// depends on sws_pkg
`timescale 1ns / 1ps
`default_nettype none

module sws_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire sws_pkg::rec_group_t group,
    input  wire logic                pop,
    output sws_pkg::record_t         head,
    output logic                     not_empty,
    output logic                     room
);
    import sws_pkg::*;

    localparam int DEPTH = 4;

    record_t     mem_reg [DEPTH];
    logic [1:0]  wr_ptr_reg;
    logic [1:0]  wr_ptr_next;
    logic [1:0]  rd_ptr_reg;
    logic [1:0]  rd_ptr_next;
    logic [2:0]  count_reg;
    logic [2:0]  count_next;
    logic [2:0]  count_after_pop;
    logic [1:0]  push_n;
    logic        do_pop;

    assign do_pop          = pop && (count_reg != 3'd0);
    assign push_n          = push ? group.count : 2'd0;
    assign count_after_pop = count_reg - {2'b00, do_pop};
    // a byte may need three slots
    assign room            = (count_after_pop <= 3'd1);
    assign count_next      = count_after_pop + {1'b0, push_n};
    assign wr_ptr_next     = wr_ptr_reg + push_n;
    assign rd_ptr_next     = rd_ptr_reg + {1'b0, do_pop};

    assign head      = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != 3'd0);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RECS; i++)
        begin
            if (2'(i) < push_n)
                mem_reg[wr_ptr_reg + 2'(i)] <= group.rec[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> design/shell_word_splitter.sv
// shell word splitter: one command byte a request in, word records out
// an accepted byte is registered, then parsed and its records written into the result queue
// throughput: one byte per cycle while each byte gives at most one record and the
//   receiver does not stall; bytes giving two or three records may hold the input
//   while the four-entry result queue drains one record a cycle
// reset: asynchronous, active low; delimiter state, no word open, queue empty
`timescale 1ns / 1ps
`default_nettype none

module shell_word_splitter (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       char_valid,
    output logic            char_stall,
    input  wire logic [7:0] char_in,
    output logic            rec_valid,
    input  wire logic       rec_stall,
    output logic [1:0]      record_kind,
    output logic [7:0]      char_out,
    output logic            last_of_run
);
    import sws_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  char_reg;
    logic        room;
    logic        move;
    rec_group_t  group;
    record_t     head;

    // the held byte is parsed when the queue has room for three records, the most one byte gives
    assign move       = in_valid_reg && room;
    assign char_stall = in_valid_reg && !room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!char_stall)
            in_valid_reg <= char_valid;
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
            char_reg <= char_in;
    end

    sws_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (move),
        .ch    (char_reg),
        .group (group)
    );

    sws_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (move),
        .group     (group),
        .pop       (!rec_stall),
        .head      (head),
        .not_empty (rec_valid),
        .room      (room)
    );

    assign record_kind = head.kind;
    assign char_out    = head.ch;
    assign last_of_run = head.last;

endmodule

`default_nettype wire

>>> sim/shell_word_splitter_test.sv
// self-checking bench for shell_word_splitter: byte requests in, word records out
// predicts every record in-line and compares in order; depends on sws_pkg and the design
`timescale 1ns / 1ps

module shell_word_splitter_test;

    import sws_pkg::*;

    localparam int LONG_HOLD    = 80;
    localparam int DRAIN_CYCLES = 12;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       char_valid = 1'b0;
    logic [7:0] char_in    = 8'h00;
    logic       rec_stall  = 1'b0;
    logic       char_stall;
    logic       rec_valid;
    logic [1:0] record_kind;
    logic [7:0] char_out;
    logic       last_of_run;

    // predictor state
    logic [2:0] parse_st = ST_DELIM;
    logic       word_on  = 1'b0;
    record_t    pending_records[$];

    int errors      = 0;
    int sent_items  = 0;
    bit tx_quiet    = 1'b0;
    bit rx_quiet    = 1'b0;
    int hold_req    = 0;
    int hold_served = 0;
    int stall_left  = 0;

    shell_word_splitter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .char_in     (char_in),
        .rec_valid   (rec_valid),
        .rec_stall   (rec_stall),
        .record_kind (record_kind),
        .char_out    (char_out),
        .last_of_run (last_of_run)
    );

    always #5 clk = ~clk;

    function automatic record_t word_record(input logic [1:0] kind, input logic [7:0] ch);
        record_t r;
        r.kind = kind;
        r.ch   = (kind == K_CHAR) ? ch : 8'h00;
        r.last = 1'b0;
        return r;
    endfunction

    // advance the quoting state by one byte and queue the records it causes
    function automatic void split_byte(input logic [7:0] c);
        record_t    recs[$];
        logic [2:0] st;
        logic       done;
        logic       blank;
        st    = parse_st;
        done  = 1'b0;
        blank = (c == CH_TAB || c == CH_SPACE || c == CH_NL);
        case (st)
            ST_DELIM, ST_COMMENT:
            begin
                if (c == CH_NUL)
                begin
                    if (word_on)
                        recs.push_back(word_record(K_EOW, 8'h00));
                    recs.push_back(word_record(K_EOC, 8'h00));
                    done = 1'b1;
                end
                else if (st == ST_COMMENT)
                begin
                    // newline ends the comment but leaves an open word open
                    if (c == CH_NL)
                        st = ST_DELIM;
                end
                else if (c == CH_SQUOTE)
                    st = ST_SQ;
                else if (c == CH_DQUOTE)
                    st = ST_DQ;
                else if (c == CH_BACKSLASH)
                    st = ST_BSLASH;
                else if (blank)
                    st = ST_DELIM;
                else if (c == CH_HASH)
                    st = ST_COMMENT;
                else
                begin
                    recs.push_back(word_record(K_CHAR, c));
                    word_on = 1'b1;
                    st = ST_UNQ;
                end
            end
            ST_BSLASH, ST_UNQ_BSLASH:
            begin
                if (c == CH_NUL)
                begin
                    recs.push_back(word_record(K_CHAR, CH_BACKSLASH));
                    recs.push_back(word_record(K_EOW, 8'h00));
                    recs.push_back(word_record(K_EOC, 8'h00));
                    done = 1'b1;
                end
                else if (c == CH_NL)
                    st = (st == ST_BSLASH) ? ST_DELIM : ST_UNQ;
                else
                begin
                    recs.push_back(word_record(K_CHAR, c));
                    word_on = 1'b1;
                    st = ST_UNQ;
                end
            end
            ST_UNQ:
            begin
                if (c == CH_NUL)
                begin
                    recs.push_back(word_record(K_EOW, 8'h00));
                    recs.push_back(word_record(K_EOC, 8'h00));
                    done = 1'b1;
                end
                else if (c == CH_SQUOTE)
                    st = ST_SQ;
                else if (c == CH_DQUOTE)
                    st = ST_DQ;
                else if (c == CH_BACKSLASH)
                    st = ST_UNQ_BSLASH;
                else if (blank)
                begin
                    recs.push_back(word_record(K_EOW, 8'h00));
                    word_on = 1'b0;
                    st = ST_DELIM;
                end
                else if (c == CH_HASH)
                    st = ST_COMMENT;
                else
                begin
                    recs.push_back(word_record(K_CHAR, c));
                    word_on = 1'b1;
                end
            end
            ST_SQ:
            begin
                if (c == CH_NUL)
                begin
                    recs.push_back(word_record(K_ERR, 8'h00));
                    done = 1'b1;
                end
                else if (c == CH_SQUOTE)
                    st = ST_UNQ;
                else
                begin
                    recs.push_back(word_record(K_CHAR, c));
                    word_on = 1'b1;
                end
            end
            ST_DQ:
            begin
                if (c == CH_NUL)
                begin
                    recs.push_back(word_record(K_ERR, 8'h00));
                    done = 1'b1;
                end
                else if (c == CH_DQUOTE)
                    st = ST_UNQ;
                else if (c == CH_BACKSLASH)
                    st = ST_DQ_BSLASH;
                else
                begin
                    recs.push_back(word_record(K_CHAR, c));
                    word_on = 1'b1;
                end
            end
            default:
            begin
                if (c == CH_NUL)
                begin
                    recs.push_back(word_record(K_ERR, 8'h00));
                    done = 1'b1;
                end
                else if (c == CH_NL)
                    st = ST_DQ;
                else if (c == CH_DOLLAR || c == CH_BACKTICK ||
                         c == CH_DQUOTE || c == CH_BACKSLASH)
                begin
                    recs.push_back(word_record(K_CHAR, c));
                    word_on = 1'b1;
                    st = ST_DQ;
                end
                else
                begin
                    // escape not special inside double quotes: keep both
                    recs.push_back(word_record(K_CHAR, CH_BACKSLASH));
                    recs.push_back(word_record(K_CHAR, c));
                    word_on = 1'b1;
                    st = ST_DQ;
                end
            end
        endcase
        if (done)
        begin
            st = ST_DELIM;
            word_on = 1'b0;
        end
        parse_st = st;
        if (recs.size() > 0)
            recs[recs.size()-1].last = 1'b1;
        foreach (recs[i])
            pending_records.push_back(recs[i]);
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    // record checker
    always @(posedge clk)
    begin
        record_t want;
        if (rst_n && rec_valid && !rec_stall)
        begin
            if (pending_records.size() == 0)
                report_mismatch($sformatf("record kind %0d char %02h with nothing pending",
                                          record_kind, char_out));
            else
            begin
                want = pending_records.pop_front();
                if (record_kind !== want.kind)
                    report_mismatch($sformatf("record_kind %0d, want %0d",
                                              record_kind, want.kind));
                if (char_out !== want.ch)
                    report_mismatch($sformatf("char_out %02h, want %02h",
                                              char_out, want.ch));
                if (last_of_run !== want.last)
                    report_mismatch($sformatf("last_of_run %0b, want %0b",
                                              last_of_run, want.last));
            end
        end
    end

    // receiver: random stall bursts, plus a long hold-off when asked
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                rec_stall <= 1'b1;
                stall_left--;
            end
            else if (hold_req != hold_served)
            begin
                hold_served = hold_req;
                rec_stall <= 1'b1;
                stall_left = LONG_HOLD - 1;
            end
            else if (!rx_quiet && $urandom_range(0, 9) == 0)
            begin
                rec_stall <= 1'b1;
                stall_left = $urandom_range(0, 9);
            end
            else
                rec_stall <= 1'b0;
        end
    end

    initial
    begin
        #2_000_000;
        $display("shell_word_splitter_test failed");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (!tx_quiet && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 10);
            @(negedge clk) char_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        char_valid <= 1'b1;
        char_in    <= b;
        @(posedge clk);
        while (char_stall)
            @(posedge clk);
        split_byte(b);
        sent_items++;
    endtask

    task automatic send_cmd(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
        send_byte(CH_NUL);
    endtask

    task automatic wait_drain();
        @(negedge clk) char_valid <= 1'b0;
        while (pending_records.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (b == CH_TAB || b == CH_NL || b == CH_SPACE || b == CH_DQUOTE ||
               b == CH_HASH || b == CH_SQUOTE || b == CH_BACKSLASH);
        return b;
    endfunction

    // mostly well-formed commands with random content, some noise and open quotes
    task automatic random_command();
        int         ntok;
        int         len;
        logic [7:0] b;
        bit         broken;
        if ($urandom_range(0, 9) == 0)
        begin
            len = $urandom_range(1, 8);
            repeat (len) send_byte(8'($urandom_range(0, 255)));
            send_byte(CH_NUL);
            return;
        end
        broken = ($urandom_range(0, 7) == 0);
        ntok = $urandom_range(1, 6);
        for (int k = 0; k < ntok; k++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                    repeat ($urandom_range(1, 4)) send_byte(plain_byte());
                3:
                begin
                    send_byte(CH_SQUOTE);
                    repeat ($urandom_range(0, 3))
                    begin
                        b = 8'($urandom_range(1, 255));
                        if (b != CH_SQUOTE)
                            send_byte(b);
                    end
                    if (broken)
                        break;
                    send_byte(CH_SQUOTE);
                end
                4:
                begin
                    send_byte(CH_DQUOTE);
                    repeat ($urandom_range(0, 3))
                    begin
                        if ($urandom_range(0, 2) == 0)
                        begin
                            send_byte(CH_BACKSLASH);
                            case ($urandom_range(0, 5))
                                0: send_byte(CH_DOLLAR);
                                1: send_byte(CH_BACKTICK);
                                2: send_byte(CH_DQUOTE);
                                3: send_byte(CH_BACKSLASH);
                                4: send_byte(CH_NL);
                                default: send_byte(plain_byte());
                            endcase
                        end
                        else
                        begin
                            b = 8'($urandom_range(1, 255));
                            if (b != CH_DQUOTE && b != CH_BACKSLASH)
                                send_byte(b);
                        end
                    end
                    if (broken)
                        break;
                    send_byte(CH_DQUOTE);
                end
                5:
                begin
                    send_byte(CH_BACKSLASH);
                    if (broken)
                        break;
                    send_byte(8'($urandom_range(1, 255)));
                end
                6:
                begin
                    send_byte(CH_HASH);
                    repeat ($urandom_range(0, 3)) send_byte(plain_byte());
                    send_byte(CH_NL);
                end
                default:
                begin
                    case ($urandom_range(0, 2))
                        0: send_byte(CH_SPACE);
                        1: send_byte(CH_TAB);
                        default: send_byte(CH_NL);
                    endcase
                end
            endcase
        end
        send_byte(CH_NUL);
    endtask

    task automatic test_directed();
        send_cmd("''");
        send_cmd("a#x\nb");
        send_cmd("\\");
        send_cmd("\"\\$\\q\\\n");
        send_cmd("\377\\\n\001\t#");
        wait_drain();
    endtask

    task automatic test_random(input int n);
        int target;
        target = sent_items + n;
        while (sent_items < target)
            random_command();
    endtask

    // receiver holds off while requests keep coming, so the queue fills
    task automatic test_backpressure();
        tx_quiet = 1'b1;
        hold_req++;
        repeat (30) send_byte(plain_byte());
        send_cmd("x\"\\q\" '' y\\");
        tx_quiet = 1'b0;
        wait_drain();
    endtask

    task automatic test_quiet_tail(input int n);
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        test_random(n);
        wait_drain();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
        test_directed();
        test_random(200);
        test_backpressure();
        test_random(40);
        test_quiet_tail(70);
        if (errors == 0)
            $display("shell_word_splitter_test passed");
        else
            $display("shell_word_splitter_test failed");
        $finish;
    end

endmodule

>>> files.f
design/sws_pkg.sv
design/sws_parser.sv
design/sws_queue.sv
design/shell_word_splitter.sv
sim/shell_word_splitter_test.sv
